// ===== design/surd_pkg.sv =====
package surd_pkg;

  // width of the data ports, fixed by the interface
  localparam int PORT_WIDTH = 64;

  // default operand width handled by the datapath
  localparam int DATA_WIDTH_DEFAULT = 64;

  // sign and error flags that ride along with each transaction
  typedef struct packed {
    logic num_neg;
    logic den_neg;
    logic den_zero;
  } surd_flags_t;

endpackage

// ===== design/signed_unsigned_restoring_divider.sv =====
// pipelined restoring divider, unsigned or signed two's complement
// input channel: in_valid/in_ready carry kind, dividend and divisor;
// output channel: out_valid/out_ready carry quotient, remainder and
// divide_by_zero, one result transaction per input transaction, in order
// the pipe has an input register that takes operand magnitudes, one cell per
// quotient bit, and the output register, which does the sign fix
// throughput is one transaction per cycle unless the receiver stalls; every register stage
// holds one transaction in flight, so up to DATA_WIDTH + 2 transactions are in the pipe
// only the low DATA_WIDTH bits of the operands are used, results are
// zero-extended to the port width
// a zero divisor sets divide_by_zero, quotient all ones, remainder = dividend
// reset empties the pipe; nothing is kept between transactions
// when the receiver stalls, stages fill up behind the output register and
// empty slots keep accepting; in_ready drops only once the whole pipe is full
module signed_unsigned_restoring_divider #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [surd_pkg::PORT_WIDTH-1:0] dividend,
  input  logic [surd_pkg::PORT_WIDTH-1:0] divisor,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [surd_pkg::PORT_WIDTH-1:0] quotient,
  output logic [surd_pkg::PORT_WIDTH-1:0] remainder,
  output logic                            divide_by_zero
);
  import surd_pkg::*;

  // link i feeds cell i; link DATA_WIDTH feeds the output stage
  logic                  link_valid [0:DATA_WIDTH];
  logic                  link_ready [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] link_part  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] link_numq  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] link_den   [0:DATA_WIDTH];
  surd_flags_t           link_flags [0:DATA_WIDTH];

  surd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_kind    (kind),
    .up_dividend(dividend),
    .up_divisor (divisor),
    .down_valid (link_valid[0]),
    .down_ready (link_ready[0]),
    .down_part  (link_part[0]),
    .down_numq  (link_numq[0]),
    .down_den   (link_den[0]),
    .down_flags (link_flags[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    surd_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (link_valid[i]),
      .up_ready  (link_ready[i]),
      .up_part   (link_part[i]),
      .up_numq   (link_numq[i]),
      .up_den    (link_den[i]),
      .up_flags  (link_flags[i]),
      .down_valid(link_valid[i+1]),
      .down_ready(link_ready[i+1]),
      .down_part (link_part[i+1]),
      .down_numq (link_numq[i+1]),
      .down_den  (link_den[i+1]),
      .down_flags(link_flags[i+1])
    );
  end

  surd_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk                (clk),
    .rst                (rst),
    .up_valid           (link_valid[DATA_WIDTH]),
    .up_ready           (link_ready[DATA_WIDTH]),
    .up_part            (link_part[DATA_WIDTH]),
    .up_numq            (link_numq[DATA_WIDTH]),
    .up_flags           (link_flags[DATA_WIDTH]),
    .down_valid         (out_valid),
    .down_ready         (out_ready),
    .down_quotient      (quotient),
    .down_remainder     (remainder),
    .down_divide_by_zero(divide_by_zero)
  );

  // the input side backs up only when the output is held by the receiver
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output is free");

  // a zero divisor always reports an all-ones quotient
  a_dbz_quotient: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (quotient[DATA_WIDTH-1:0] == '1))
    else $error("divide by zero without all-ones quotient");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

  // the final partial remainder of a nonzero divisor is below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (link_valid[DATA_WIDTH] && !link_flags[DATA_WIDTH].den_zero)
      |-> (link_part[DATA_WIDTH] < link_den[DATA_WIDTH]))
    else $error("partial remainder not reduced below divisor");

endmodule

// ===== design/surd_prep.sv =====
module surd_prep #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic                            up_kind,
  input  logic [surd_pkg::PORT_WIDTH-1:0] up_dividend,
  input  logic [surd_pkg::PORT_WIDTH-1:0] up_divisor,
  output logic                            down_valid,
  input  logic                            down_ready,
  output logic [DATA_WIDTH-1:0]           down_part,
  output logic [DATA_WIDTH-1:0]           down_numq,
  output logic [DATA_WIDTH-1:0]           down_den,
  output surd_pkg::surd_flags_t           down_flags
);
  import surd_pkg::*;

  logic [DATA_WIDTH-1:0] num_raw;
  logic [DATA_WIDTH-1:0] den_raw;
  logic [DATA_WIDTH-1:0] num_mag;
  logic [DATA_WIDTH-1:0] den_mag;
  surd_flags_t           flags_next;

  logic                  valid;
  logic [DATA_WIDTH-1:0] numq;
  logic [DATA_WIDTH-1:0] den;
  surd_flags_t           flags;

  assign num_raw = up_dividend[DATA_WIDTH-1:0];
  assign den_raw = up_divisor[DATA_WIDTH-1:0];

  always_comb begin
    flags_next.num_neg  = up_kind & num_raw[DATA_WIDTH-1];
    flags_next.den_neg  = up_kind & den_raw[DATA_WIDTH-1];
    num_mag = flags_next.num_neg ? (~num_raw + 1'b1) : num_raw;
    den_mag = flags_next.den_neg ? (~den_raw + 1'b1) : den_raw;
    flags_next.den_zero = (den_raw == '0);
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      numq  <= num_mag;
      den   <= den_mag;
      flags <= flags_next;
    end
  end

  assign down_valid = valid;
  assign down_part  = '0;
  assign down_numq  = numq;
  assign down_den   = den;
  assign down_flags = flags;

endmodule

// ===== design/surd_cell.sv =====
module surd_cell #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [DATA_WIDTH-1:0] up_part,
  input  logic [DATA_WIDTH-1:0] up_numq,
  input  logic [DATA_WIDTH-1:0] up_den,
  input  surd_pkg::surd_flags_t up_flags,
  output logic                  down_valid,
  input  logic                  down_ready,
  output logic [DATA_WIDTH-1:0] down_part,
  output logic [DATA_WIDTH-1:0] down_numq,
  output logic [DATA_WIDTH-1:0] down_den,
  output surd_pkg::surd_flags_t down_flags
);
  import surd_pkg::*;

  logic                  carry;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] part_next;
  logic [DATA_WIDTH-1:0] numq_next;

  logic                  valid;
  logic [DATA_WIDTH-1:0] part;
  logic [DATA_WIDTH-1:0] numq;
  logic [DATA_WIDTH-1:0] den;
  surd_flags_t           flags;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    carry     = up_part[DATA_WIDTH-1];
    shifted   = {up_part[DATA_WIDTH-2:0], up_numq[DATA_WIDTH-1]};
    diff      = {1'b0, shifted} - {1'b0, up_den};
    // the bit shifted out of the top makes the partial remainder big enough
    take      = carry || !diff[DATA_WIDTH];
    part_next = take ? diff[DATA_WIDTH-1:0] : shifted;
    // quotient bits fill the dividend register from the bottom
    numq_next = {up_numq[DATA_WIDTH-2:0], take};
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      part  <= part_next;
      numq  <= numq_next;
      den   <= up_den;
      flags <= up_flags;
    end
  end

  assign down_valid = valid;
  assign down_part  = part;
  assign down_numq  = numq;
  assign down_den   = den;
  assign down_flags = flags;

endmodule

// ===== design/surd_post.sv =====
module surd_post #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic [DATA_WIDTH-1:0]           up_part,
  input  logic [DATA_WIDTH-1:0]           up_numq,
  input  surd_pkg::surd_flags_t           up_flags,
  output logic                            down_valid,
  input  logic                            down_ready,
  output logic [surd_pkg::PORT_WIDTH-1:0] down_quotient,
  output logic [surd_pkg::PORT_WIDTH-1:0] down_remainder,
  output logic                            down_divide_by_zero
);
  import surd_pkg::*;

  logic [DATA_WIDTH-1:0] quo_next;
  logic [DATA_WIDTH-1:0] rem_next;

  logic                  valid;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  logic                  dbz;

  always_comb begin
    if (up_flags.den_zero) begin
      quo_next = '1;
    end else if (up_flags.num_neg != up_flags.den_neg) begin
      quo_next = ~up_numq + 1'b1;
    end else begin
      quo_next = up_numq;
    end
    rem_next = up_flags.num_neg ? (~up_part + 1'b1) : up_part;
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      quo <= quo_next;
      rem <= rem_next;
      dbz <= up_flags.den_zero;
    end
  end

  assign down_valid          = valid;
  assign down_quotient       = PORT_WIDTH'(quo);
  assign down_remainder      = PORT_WIDTH'(rem);
  assign down_divide_by_zero = dbz;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import surd_pkg::*;

  localparam int PW = PORT_WIDTH;
  localparam int W = DATA_WIDTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_DIVISIONS = 1100;
  localparam int DRAIN_CYCLES = W + 16;

  localparam bit KIND_UNSIGNED = 1'b0;
  localparam bit KIND_SIGNED = 1'b1;

  localparam logic [PW-1:0] ALL_ONES = {PW{1'b1}};
  localparam logic [PW-1:0] MOST_NEG = {1'b1, {(PW-1){1'b0}}};
  localparam logic [PW-1:0] MOST_POS = {1'b0, {(PW-1){1'b1}}};

  typedef struct {
    bit            kind;
    logic [PW-1:0] dividend;
    logic [PW-1:0] divisor;
    logic [PW-1:0] quotient;
    logic [PW-1:0] remainder;
    logic          divide_by_zero;
  } division_t;

  class division_scoreboard;
    division_t pending[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // restoring shift-subtract on magnitudes, then sign fix-up
    function division_t predict_division(bit is_signed, logic [PW-1:0] a, logic [PW-1:0] b);
      logic [W-1:0] num;
      logic [W-1:0] den;
      logic [W-1:0] quo;
      logic [W-1:0] part;
      logic         carry;
      bit           num_neg;
      bit           den_neg;
      int           i;
      division_t    d;
      num = a[W-1:0];
      den = b[W-1:0];
      num_neg = 1'b0;
      den_neg = 1'b0;
      if (is_signed) begin
        if (num[W-1]) begin
          num_neg = 1'b1;
          num = -num;
        end
        if (den[W-1]) begin
          den_neg = 1'b1;
          den = -den;
        end
      end
      quo = '0;
      part = '0;
      for (i = W - 1; i >= 0; i--) begin
        carry = part[W-1];
        part = {part[W-2:0], num[i]};
        quo = {quo[W-2:0], 1'b0};
        // the bit shifted out on top means part already exceeds den
        if (carry || part >= den) begin
          part = part - den;
          quo[0] = 1'b1;
        end
      end
      if (den == '0)
        quo = '1;
      else if (num_neg != den_neg)
        quo = -quo;
      if (num_neg)
        part = -part;
      d.kind = is_signed;
      d.dividend = a;
      d.divisor = b;
      d.quotient = '0;
      d.quotient[W-1:0] = quo;
      d.remainder = '0;
      d.remainder[W-1:0] = part;
      d.divide_by_zero = (den == '0);
      return d;
    endfunction

    function void note_division(bit is_signed, logic [PW-1:0] a, logic [PW-1:0] b);
      pending.push_back(predict_division(is_signed, a, b));
    endfunction

    task check_result(logic [PW-1:0] q, logic [PW-1:0] r, logic dz);
      division_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding q=%h r=%h dz=%b", q, r, dz));
      end else begin
        e = pending.pop_front();
        if (q !== e.quotient)
          report_mismatch($sformatf("kind=%b %h / %h quotient %h, want %h",
                                    e.kind, e.dividend, e.divisor, q, e.quotient));
        if (r !== e.remainder)
          report_mismatch($sformatf("kind=%b %h / %h remainder %h, want %h",
                                    e.kind, e.dividend, e.divisor, r, e.remainder));
        if (dz !== e.divide_by_zero)
          report_mismatch($sformatf("kind=%b %h / %h divide_by_zero %b, want %b",
                                    e.kind, e.dividend, e.divisor, dz, e.divide_by_zero));
      end
    endtask

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic          kind;
  logic [PW-1:0] dividend;
  logic [PW-1:0] divisor;
  logic          out_valid;
  logic          out_ready;
  logic [PW-1:0] quotient;
  logic [PW-1:0] remainder;
  logic          divide_by_zero;

  division_scoreboard book;
  int                 cycle_count;
  int                 divisions_sent;

  signed_unsigned_restoring_divider uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .dividend(dividend),
    .divisor(divisor),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .quotient(quotient),
    .remainder(remainder),
    .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    dividend = '0;
    divisor = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    divisions_sent = 0;
    book = new();
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL signed_unsigned_restoring_divider");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      book.check_result(quotient, remainder, divide_by_zero);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_idle(bit calm);
    int roll;
    if (calm)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    else if (roll < 88)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 90);
  endfunction

  // receiver side: random back-pressure, with calm stretches
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_idle(((cycle_count / 700) % 3) == 0);
      end
    end
  end

  function automatic logic [PW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PW-1:0] pick_special();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return ALL_ONES;
      3: return MOST_NEG;
      4: return MOST_POS;
      5: return MOST_NEG + 1;
      6: return ALL_ONES - 1;
      default: return 2;
    endcase
  endfunction

  // wide spread of magnitudes so quotients range from 0 to full width
  function automatic logic [PW-1:0] pick_operand(int zero_pct);
    int            roll;
    logic [PW-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct)
      return '0;
    roll = $urandom_range(0, 99);
    if (roll < 12)
      return pick_special();
    v = rand_word();
    if (roll < 50)
      return v;
    v = v >> $urandom_range(1, PW - 1);
    // sometimes make it negative in signed view
    if ($urandom_range(0, 2) == 0)
      v = -v;
    return v;
  endfunction

  task send_division(bit k, logic [PW-1:0] a, logic [PW-1:0] b);
    int gap;
    gap = pick_idle(((divisions_sent / 150) % 4) == 1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    dividend <= a;
    divisor <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_division(k, a, b);
    divisions_sent++;
  endtask

  task send_directed();
    send_division(KIND_UNSIGNED, '0, 1);
    send_division(KIND_UNSIGNED, ALL_ONES, 1);
    send_division(KIND_UNSIGNED, ALL_ONES, ALL_ONES);
    send_division(KIND_UNSIGNED, ALL_ONES - 1, ALL_ONES);
    // divisor with top bit set, unsigned
    send_division(KIND_UNSIGNED, ALL_ONES, MOST_NEG);
    send_division(KIND_UNSIGNED, MOST_NEG + 5, MOST_NEG + 1);
    send_division(KIND_UNSIGNED, 64'd100, 64'd7);
    // zero divisor, both kinds and both dividend signs
    send_division(KIND_UNSIGNED, 64'h0123_4567_89ab_cdef, '0);
    send_division(KIND_UNSIGNED, '0, '0);
    send_division(KIND_SIGNED, -64'sd12345, '0);
    send_division(KIND_SIGNED, 64'd12345, '0);
    send_division(KIND_SIGNED, MOST_NEG, '0);
    // signed overflow wraps
    send_division(KIND_SIGNED, MOST_NEG, ALL_ONES);
    send_division(KIND_SIGNED, MOST_NEG, 1);
    send_division(KIND_SIGNED, MOST_NEG, MOST_NEG);
    send_division(KIND_SIGNED, ALL_ONES, MOST_NEG);
    send_division(KIND_SIGNED, MOST_POS, ALL_ONES);
    send_division(KIND_SIGNED, MOST_POS, MOST_NEG);
    // all four sign combinations
    send_division(KIND_SIGNED, 64'd7, 64'd2);
    send_division(KIND_SIGNED, -64'sd7, 64'd2);
    send_division(KIND_SIGNED, 64'd7, -64'sd2);
    send_division(KIND_SIGNED, -64'sd7, -64'sd2);
    send_division(KIND_SIGNED, -64'sd1, 64'd3);
    send_division(KIND_UNSIGNED, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_division(KIND_SIGNED, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
  endtask

  initial begin
    logic [PW-1:0] a;
    logic [PW-1:0] b;
    bit            k;
    int            n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_directed();
    for (n = 0; n < RANDOM_DIVISIONS; n++) begin
      k = 1'($urandom_range(0, 1));
      b = pick_operand(4);
      if ($urandom_range(0, 9) == 0)
        a = b * ($urandom_range(0, 1000));  // multiple of b: zero remainder unless the product wraps
      else
        a = pick_operand(3);
      send_division(k, a, b);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0)
      $display("PASS signed_unsigned_restoring_divider");
    else
      $display("FAIL signed_unsigned_restoring_divider");
    $finish;
  end

endmodule

// ===== files.f =====
design/surd_pkg.sv
design/surd_prep.sv
design/surd_cell.sv
design/surd_post.sv
design/signed_unsigned_restoring_divider.sv
sim/testbench.sv
